// File: src/tcw_pkg.sv
// Package for the text console writer: request codes, character codes,
// sizing constants, register indices and the request record. No dependencies.
package tcw_pkg;
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;

  localparam int CFG_DEFAULT_ATTR = 0;
  localparam int CFG_TAB_WIDTH    = 1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic       use_cursor;
    logic [6:0] col;
    logic [4:0] row;
  } req_t;
endpackage

// File: src/text_console_writer.sv
// Top level of the text console writer: front end, request queue, screen
// engine and configuration registers. Depends on tcw_pkg, tcw_queue, tcw_engine.
//
// A request is taken when start is high and busy is low; busy is high while
// the two-entry queue is full. Each request gives one result, shown for one
// cycle with out_valid; the receiver cannot stall it. A plain character,
// backspace, newline without scroll, an off-screen request or an unused
// request type goes from idle straight to the done state; a read passes
// through the read state first, a tab through the tab state, which writes
// its spaces. A scroll copies the cell memory with one read and one write per
// cycle and zeroes the bottom row. A clear sweeps every cell. No clearing
// pass at reset: cells are undefined until written or cleared.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_attr,
  input  logic       in_use_cursor,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output logic [6:0] out_cursor_col,
  output logic [4:0] out_cursor_row,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  output logic       out_scrolled,
  output logic       out_ignored
);
  logic [7:0] default_attr_r;
  logic [3:0] tab_width_r;
  tcw_pkg::req_t req, head;
  logic full, empty, pop;

  // configuration: hold until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= 8'd15; tab_width_r <= 4'd4;
    end else if (cfg_we) begin
      if (cfg_index == 1'(tcw_pkg::CFG_DEFAULT_ATTR)) default_attr_r <= cfg_data;
      else tab_width_r <= cfg_data[3:0];
    end
  end

  assign req = '{req_type: in_req_type, char_code: in_char_code, attr: in_attr,
                 use_cursor: in_use_cursor, col: in_col, row: in_row};
  assign busy = full;

  tcw_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(start && !full), .push_data(req),
    .full(full), .pop(pop), .empty(empty), .head(head)
  );

  tcw_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_eng (
    .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_head(head), .q_pop(pop),
    .default_attr(default_attr_r), .tab_width(tab_width_r),
    .out_valid(out_valid), .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr), .out_scrolled(out_scrolled),
    .out_ignored(out_ignored)
  );
endmodule

// File: src/tcw_queue.sv
// Short request queue between the accepting front end and the screen engine.
// Depends on tcw_pkg.
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tcw_pkg::req_t head
);
  tcw_pkg::req_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: src/tcw_engine.sv
// Screen engine: owns the cell memory and cursor, executes one request at a
// time (writes, tab runs, scroll copy, clear sweep). Depends on tcw_pkg.
module tcw_engine #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tcw_pkg::req_t q_head,
  output logic          q_pop,
  input  logic [7:0]    default_attr,
  input  logic [3:0]    tab_width,
  output logic          out_valid,
  output logic [6:0]    out_cursor_col,
  output logic [4:0]    out_cursor_row,
  output logic [7:0]    out_cell_char,
  output logic [7:0]    out_cell_attr,
  output logic          out_scrolled,
  output logic          out_ignored
);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS + 16);
  localparam int IW = $clog2(CELLS);
  localparam logic [AW-1:0] LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0] NCELL = AW'(CELLS);
  localparam logic [AW-1:0] NCOL  = AW'(COLUMNS);
  localparam logic [AW-1:0] LROW  = AW'(CELLS - COLUMNS);
  localparam logic [6:0]    LCOL  = 7'(COLUMNS - 1);
  localparam logic [5:0]    LROWN = 6'(ROWS - 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_TAB = 3'd1, S_SCRL = 3'd2,
                         S_ZERO = 3'd3, S_CLR = 3'd4, S_READ = 3'd5,
                         S_DONE = 3'd6;

  logic [15:0] mem [CELLS];
  logic [15:0] rd_r;
  logic [2:0]  st_r, st_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [6:0]  ncol_r, ncol_nxt;
  logic [5:0]  nrow_r, nrow_nxt;
  logic [6:0]  ccol_r, ccol_nxt;
  logic [4:0]  crow_r, crow_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  at_r, at_nxt;
  logic        scr_r, scr_nxt, ign_r, ign_nxt, rdo_r, rdo_nxt;

  logic        we;
  logic [AW-1:0] wa, ra;
  logic [15:0] wd;
  logic        rd_pending_r;

  // request decode
  logic          valid;
  logic [AW-1:0] p;
  logic [6:0]    pcol;
  logic [4:0]    prow;
  logic [7:0]    a;
  logic          last_col, last_row;
  always_comb begin
    valid = 1'b1;
    pcol = ccol_r; prow = crow_r;
    if (!q_head.use_cursor) begin
      valid = (32'(q_head.col) < COLUMNS) && (32'(q_head.row) < ROWS);
      pcol = q_head.col; prow = q_head.row;
    end
    p = AW'(prow) * NCOL + AW'(pcol);
    last_col = (pcol == LCOL);
    last_row = ({1'b0, prow} == LROWN);
    a = (q_head.attr == 8'd0) ? default_attr : q_head.attr;
  end

  always_comb begin
    st_nxt = st_r; addr_nxt = addr_r; ncol_nxt = ncol_r; nrow_nxt = nrow_r;
    ccol_nxt = ccol_r; crow_nxt = crow_r; cnt_nxt = cnt_r; at_nxt = at_r;
    scr_nxt = scr_r; ign_nxt = ign_r; rdo_nxt = 1'b0;
    we = 1'b0; wa = addr_r; wd = {at_r, tcw_pkg::SPACE_CHAR}; ra = addr_r;
    q_pop = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      S_IDLE: if (!q_empty) begin
        q_pop = 1'b1;
        scr_nxt = 1'b0; ign_nxt = 1'b0; at_nxt = a;
        ncol_nxt = ccol_r; nrow_nxt = {1'b0, crow_r};
        st_nxt = S_DONE;
        case (q_head.req_type)
          tcw_pkg::REQ_PUT: begin
            if (!valid) begin
              ign_nxt = 1'b1;
            end else if (q_head.char_code == tcw_pkg::CH_NEWLINE) begin
              ncol_nxt = 7'd0;
              if (last_row) begin
                nrow_nxt = {1'b0, prow}; scr_nxt = 1'b1;
                addr_nxt = '0; st_nxt = S_SCRL;
              end else nrow_nxt = {1'b0, prow} + 6'd1;
            end else if (q_head.char_code == tcw_pkg::CH_TAB) begin
              ncol_nxt = pcol; nrow_nxt = {1'b0, prow};
              addr_nxt = p; cnt_nxt = tab_width;
              st_nxt = S_TAB;
            end else begin
              we = 1'b1; wa = p;
              ncol_nxt = pcol; nrow_nxt = {1'b0, prow};
              if (q_head.char_code == tcw_pkg::CH_BACKSPACE) begin
                wd = {a, tcw_pkg::SPACE_CHAR};
              end else begin
                wd = {a, q_head.char_code};
                if (!last_col) ncol_nxt = pcol + 7'd1;
                else begin
                  ncol_nxt = 7'd0;
                  if (last_row) begin
                    scr_nxt = 1'b1; addr_nxt = '0; st_nxt = S_SCRL;
                  end else nrow_nxt = {1'b0, prow} + 6'd1;
                end
              end
            end
          end
          tcw_pkg::REQ_READ: begin
            if (!valid) begin
              ign_nxt = 1'b1;
            end else begin
              ra = p; addr_nxt = p; st_nxt = S_READ;
            end
          end
          tcw_pkg::REQ_CLEAR: begin
            at_nxt = default_attr; addr_nxt = '0;
            ncol_nxt = 7'd0; nrow_nxt = 6'd0; st_nxt = S_CLR;
          end
          default: st_nxt = S_DONE;
        endcase
      end
      S_TAB: begin
        // one space per cycle, drop writes past the end
        if (cnt_r == 4'd0) begin
          st_nxt = S_DONE;
          if (32'(nrow_r) >= ROWS) begin
            scr_nxt = 1'b1; addr_nxt = '0; st_nxt = S_SCRL;
            if (32'(nrow_r) > ROWS) begin
              ncol_nxt = LCOL; nrow_nxt = LROWN;
            end else nrow_nxt = nrow_r - 6'd1;
          end
        end else begin
          we = (addr_r < NCELL); wa = addr_r;
          addr_nxt = addr_r + 1'b1; cnt_nxt = cnt_r - 1'b1;
          if (ncol_r == LCOL) begin
            ncol_nxt = 7'd0; nrow_nxt = nrow_r + 6'd1;
          end else ncol_nxt = ncol_r + 7'd1;
        end
      end
      S_SCRL: begin
        // read source in one cycle, write destination in the next
        ra = addr_r + NCOL;
        if (rd_pending_r) begin
          we = 1'b1; wa = addr_r - 1'b1; wd = rd_r;
        end
        if (addr_r == LROW) begin
          if (rd_pending_r) begin addr_nxt = LROW; st_nxt = S_ZERO; end
        end else addr_nxt = addr_r + 1'b1;
      end
      S_ZERO: begin
        we = 1'b1; wa = addr_r; wd = 16'h0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST) st_nxt = S_DONE;
      end
      S_CLR: begin
        we = 1'b1; wa = addr_r; addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST) st_nxt = S_DONE;
      end
      S_READ: begin
        rdo_nxt = 1'b1; st_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1; st_nxt = S_IDLE;
        ccol_nxt = ncol_r; crow_nxt = nrow_r[4:0];
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic scroll_rd;
  assign scroll_rd = (st_r == S_SCRL) && !(addr_r == LROW && rd_pending_r);

  always_ff @(posedge clk) begin
    if (we) mem[wa[IW-1:0]] <= wd;
    rd_r <= mem[(ra < NCELL) ? ra[IW-1:0] : {IW{1'b0}}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ccol_r <= '0; crow_r <= '0;
      rd_pending_r <= 1'b0; rdo_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ccol_r <= ccol_nxt; crow_r <= crow_nxt;
      rd_pending_r <= scroll_rd; rdo_r <= rdo_nxt;
    end
    addr_r <= addr_nxt; ncol_r <= ncol_nxt; nrow_r <= nrow_nxt;
    cnt_r <= cnt_nxt; at_r <= at_nxt;
    scr_r <= scr_nxt; ign_r <= ign_nxt;
  end

  assign out_cursor_col = ncol_r;
  assign out_cursor_row = nrow_r[4:0];
  assign out_cell_char  = rdo_r ? rd_r[7:0] : 8'd0;
  assign out_cell_attr  = rdo_r ? rd_r[15:8] : 8'd0;
  assign out_scrolled   = scr_r;
  assign out_ignored    = ign_r;
endmodule

// File: tb/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: queue-fed request driver,
// result monitor and a cycle-free predictor of the screen and cursor.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int CELLS      = COLUMNS_DEF * ROWS_DEF;
  localparam int SETTLE_CYC = 20;   // idle cycles before a register write
  localparam int TAIL_CYC   = 50;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t   kind;
    req_t       r;
    logic       idx;
    logic [7:0] data;
  } console_op_t;

  typedef struct packed {
    logic [6:0] ccol;
    logic [4:0] crow;
    logic [7:0] ch;
    logic [7:0] at;
    logic       scr;
    logic       ign;
  } console_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_req_type;
  logic [7:0] in_char_code;
  logic [7:0] in_attr;
  logic       in_use_cursor;
  logic [6:0] in_col;
  logic [4:0] in_row;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;
  logic       out_valid;
  logic [6:0] out_cursor_col;
  logic [4:0] out_cursor_row;
  logic [7:0] out_cell_char;
  logic [7:0] out_cell_attr;
  logic       out_scrolled;
  logic       out_ignored;

  // Stimulus and scoreboard storage
  console_op_t     pending_ops[$];
  console_result_t expected_results[$];
  req_t            cur_req;
  int              sent_reqs;
  int              settle_cnt;
  bit              driver_done;
  int              fail_cnt;

  // Shadow of the screen state
  logic [15:0] shadow_screen[CELLS];
  int          shadow_cursor;
  logic [7:0]  shadow_attr;
  logic [3:0]  shadow_tab;

  text_console_writer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_char_code(in_char_code), .in_attr(in_attr),
    .in_use_cursor(in_use_cursor), .in_col(in_col), .in_row(in_row),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row), .out_cell_char(out_cell_char),
    .out_cell_attr(out_cell_attr), .out_scrolled(out_scrolled),
    .out_ignored(out_ignored)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one accepted request to the shadow screen and queue its result.
  task automatic apply_console_req(input req_t r);
    console_result_t res;
    int  p, np, a, i;
    bit  on_screen;
    res = '0;
    p = 0;
    on_screen = 1'b1;
    if (r.req_type == REQ_PUT || r.req_type == REQ_READ) begin
      if (r.use_cursor)
        p = shadow_cursor;
      else if (r.col >= COLUMNS_DEF || r.row >= ROWS_DEF)
        on_screen = 1'b0;
      else
        p = int'(r.row) * COLUMNS_DEF + int'(r.col);
      res.ign = !on_screen;
    end
    if (r.req_type == REQ_PUT && on_screen) begin
      a = (r.attr == 8'd0) ? int'(shadow_attr) : int'(r.attr);
      if (r.char_code == CH_NEWLINE) begin
        np = (p / COLUMNS_DEF + 1) * COLUMNS_DEF;
      end else if (r.char_code == CH_BACKSPACE) begin
        shadow_screen[p] = {a[7:0], SPACE_CHAR};
        np = p;
      end else if (r.char_code == CH_TAB) begin
        for (i = 0; i < int'(shadow_tab); i++)
          if (p + i < CELLS) shadow_screen[p + i] = {a[7:0], SPACE_CHAR};
        np = p + int'(shadow_tab);
      end else begin
        shadow_screen[p] = {a[7:0], r.char_code};
        np = p + 1;
      end
      // Past the last cell: scroll up one row and zero the bottom row
      if (np >= CELLS) begin
        for (i = 0; i < CELLS - COLUMNS_DEF; i++)
          shadow_screen[i] = shadow_screen[i + COLUMNS_DEF];
        for (i = CELLS - COLUMNS_DEF; i < CELLS; i++)
          shadow_screen[i] = 16'h0000;
        res.scr = 1'b1;
        np -= COLUMNS_DEF;
        if (np >= CELLS) np = CELLS - 1;
      end
      shadow_cursor = np;
    end else if (r.req_type == REQ_READ && on_screen) begin
      res.ch = shadow_screen[p][7:0];
      res.at = shadow_screen[p][15:8];
    end else if (r.req_type == REQ_CLEAR) begin
      for (i = 0; i < CELLS; i++) shadow_screen[i] = {shadow_attr, SPACE_CHAR};
      shadow_cursor = 0;
    end
    res.ccol = 7'(shadow_cursor % COLUMNS_DEF);
    res.crow = 5'(shadow_cursor / COLUMNS_DEF);
    expected_results.push_back(res);
  endtask

  function automatic void add_req(input logic [1:0] rt, input logic [7:0] ch,
                                  input logic [7:0] at, input logic uc,
                                  input logic [6:0] c, input logic [4:0] rw);
    console_op_t op;
    op.kind = OP_REQ;
    op.r = '{req_type: rt, char_code: ch, attr: at, use_cursor: uc, col: c, row: rw};
    op.idx = 1'b0;
    op.data = 8'd0;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_marker(input op_kind_t k, input logic idx,
                                     input logic [7:0] d);
    console_op_t op;
    op.kind = k;
    op.r = '0;
    op.idx = idx;
    op.data = d;
    pending_ops.push_back(op);
  endfunction

  // Mostly random bytes of any value, with newline, backspace and tab mixed in.
  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return CH_NEWLINE;
    if (k < 20) return CH_BACKSPACE;
    if (k < 30) return CH_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_attr();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_random_req();
    int k;
    logic [4:0] rw;
    k = $urandom_range(0, 99);
    rw = ($urandom_range(0, 9) == 0) ? 5'(ROWS_DEF - 1) : 5'($urandom_range(0, ROWS_DEF - 1));
    if (k < 50)
      add_req(REQ_PUT, pick_char(), pick_attr(), 1'b1, 7'($urandom), 5'($urandom));
    else if (k < 65)
      add_req(REQ_PUT, pick_char(), pick_attr(), 1'b0,
              7'($urandom_range(0, COLUMNS_DEF - 1)), rw);
    else if (k < 80)
      add_req(REQ_READ, 8'($urandom), 8'($urandom), 1'b0,
              7'($urandom_range(0, COLUMNS_DEF - 1)), 5'($urandom_range(0, ROWS_DEF - 1)));
    else if (k < 84)
      add_req(REQ_READ, 8'($urandom), 8'($urandom), 1'b1, 7'($urandom), 5'($urandom));
    else if (k < 92)
      // Anywhere in the field range, off screen for most picks
      add_req(2'($urandom_range(0, 1)), pick_char(), pick_attr(), 1'b0,
              7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
    else if (k < 93)
      add_req(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 5'($urandom));
    else if (k < 95)
      add_req(2'd3, 8'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 5'($urandom));
    else
      add_req(REQ_PUT, 8'($urandom), 8'($urandom), 1'($urandom), 7'($urandom), 5'($urandom));
  endfunction

  // Driver: present one request at a time, do register writes only when idle.
  always @(posedge clk) begin
    logic        n_start;
    logic        n_we;
    console_op_t op;
    bit          quiet;
    n_start = start;
    n_we = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        apply_console_req(cur_req);
        sent_reqs++;
        n_start = 1'b0;
      end
      if (expected_results.size() == 0 && !start) settle_cnt++;
      else settle_cnt = 0;
      quiet = (sent_reqs >= 700 && sent_reqs < 1000);
      if (!n_start && pending_ops.size() > 0) begin
        if (pending_ops[0].kind != OP_REQ) begin
          // Hold until every expected transfer has come and the block settles
          if (expected_results.size() == 0 && settle_cnt >= SETTLE_CYC) begin
            op = pending_ops.pop_front();
            if (op.kind == OP_CFG) begin
              n_we = 1'b1;
              cfg_index <= op.idx;
              cfg_data <= op.data;
              if (op.idx == 1'(CFG_DEFAULT_ATTR)) shadow_attr = op.data;
              else shadow_tab = op.data[3:0];
            end
            settle_cnt = 0;
          end
        end else if (quiet || $urandom_range(0, 99) >= 21) begin
          op = pending_ops.pop_front();
          cur_req = op.r;
          in_req_type <= op.r.req_type;
          in_char_code <= op.r.char_code;
          in_attr <= op.r.attr;
          in_use_cursor <= op.r.use_cursor;
          in_col <= op.r.col;
          in_row <= op.r.row;
          n_start = 1'b1;
        end
      end
      if (!n_start && pending_ops.size() == 0) driver_done = 1'b1;
    end
    start <= n_start;
    cfg_we <= n_we;
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    console_result_t got, want;
    if (rst_n && out_valid) begin
      got = {out_cursor_col, out_cursor_row, out_cell_char, out_cell_attr,
             out_scrolled, out_ignored};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result col=%0d row=%0d char=%h attr=%h scr=%b ign=%b",
                 $time, got.ccol, got.crow, got.ch, got.at, got.scr, got.ign);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected col=%0d row=%0d char=%h attr=%h scr=%b ign=%b",
                   $time, want.ccol, want.crow, want.ch, want.at, want.scr, want.ign);
          $display("%0t:          actual   col=%0d row=%0d char=%h attr=%h scr=%b ign=%b",
                   $time, got.ccol, got.crow, got.ch, got.at, got.scr, got.ign);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int ph, n;
    logic [7:0] attrs[8];
    logic [7:0] tabs[8];
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 8'd0;
    in_req_type = REQ_PUT;
    in_char_code = 8'd0;
    in_attr = 8'd0;
    in_use_cursor = 1'b0;
    in_col = 7'd0;
    in_row = 5'd0;
    sent_reqs = 0;
    settle_cnt = 0;
    driver_done = 1'b0;
    fail_cnt = 0;
    shadow_cursor = 0;
    shadow_attr = 8'd15;
    shadow_tab = 4'd4;
    foreach (shadow_screen[i]) shadow_screen[i] = 16'h0000;

    // Directed part: clear first so that no read sees an unwritten cell
    add_req(REQ_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
    add_req(REQ_PUT, 8'h41, 8'h00, 1'b0, 7'd0, 5'd0);
    add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
    add_req(REQ_PUT, 8'hFF, 8'hFF, 1'b0, 7'd79, 5'd24);       // last cell, scrolls
    add_req(REQ_READ, 8'hFF, 8'hFF, 1'b0, 7'd79, 5'd23);
    add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd24);       // zeroed bottom row
    add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 7'd127, 5'd0);      // off screen column
    add_req(REQ_PUT, 8'h42, 8'h11, 1'b0, 7'd5, 5'd31);        // off screen row
    add_req(REQ_PUT, 8'h43, 8'h22, 1'b0, 7'd80, 5'd25);
    add_req(REQ_PUT, 8'h44, 8'h00, 1'b1, 7'd0, 5'd0);
    add_req(REQ_PUT, CH_NEWLINE, 8'h00, 1'b1, 7'd0, 5'd0);
    add_req(REQ_PUT, CH_BACKSPACE, 8'h3C, 1'b0, 7'd10, 5'd3);
    add_req(REQ_PUT, CH_TAB, 8'h00, 1'b1, 7'd0, 5'd0);
    add_req(REQ_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0);
    add_req(REQ_PUT, CH_NEWLINE, 8'h00, 1'b0, 7'd40, 5'd24);  // newline from last row
    add_req(REQ_PUT, CH_TAB, 8'h7E, 1'b0, 7'd78, 5'd24);      // tab clipped, scrolls
    add_req(REQ_READ, 8'h00, 8'h00, 1'b0, 7'd78, 5'd23);
    add_req(2'd3, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
    add_req(REQ_PUT, 8'h00, 8'h01, 1'b1, 7'd127, 5'd31);

    // Random phases, each opened by writes to both registers
    attrs = '{8'd0, 8'd255, 8'd15, 8'd1, 8'd128, 8'd0, 8'd255, 8'd77};
    tabs  = '{8'd1, 8'd15, 8'd0, 8'd4, 8'd15, 8'd1, 8'd7, 8'd0};
    for (ph = 0; ph < 8; ph++) begin
      add_marker(OP_CFG, 1'(CFG_DEFAULT_ATTR),
                 (ph >= 5) ? 8'($urandom_range(0, 255)) : attrs[ph]);
      add_marker(OP_CFG, 1'(CFG_TAB_WIDTH), tabs[ph]);
      for (n = 0; n < 229; n++) begin
        add_random_req();
        if (n == 120 && ph[0]) add_marker(OP_DRAIN, 1'b0, 8'd0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (driver_done);
    wait (expected_results.size() == 0);
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_cnt == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #600ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
